// ===== design/hcbd_pkg.sv =====
`default_nettype none

package hcbd_pkg;

  // Default width of the chunk size and of the byte countdown.
  localparam int SIZE_BITS_DEF = 32;

  // Character codes used by the size line parser.
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_VT   = 8'h0B;
  localparam logic [7:0] CH_FF   = 8'h0C;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UF   = 8'h46;
  localparam logic [7:0] CH_UX   = 8'h58;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LF_A = 8'h66;
  localparam logic [7:0] CH_LX   = 8'h78;

  // Offsets from a letter's code to its hex digit value.
  localparam logic [7:0] UPPER_OFS = 8'h37;
  localparam logic [7:0] LOWER_OFS = 8'h57;

  // Top level phase of the decoder.
  typedef enum logic [2:0] {
    PH_LINE = 3'b001,
    PH_DATA = 3'b010,
    PH_DONE = 3'b100
  } phase_t;

  // Progress through the number on a size line.
  typedef enum logic [6:0] {
    NP_BEFORE = 7'b0000001,
    NP_ZERO   = 7'b0000010,
    NP_PREFIX = 7'b0000100,
    NP_DIGITS = 7'b0001000,
    NP_AFTER  = 7'b0010000,
    NP_BAD    = 7'b0100000,
    NP_OVER   = 7'b1000000
  } num_phase_t;

  // Reason reported with the end of a body.
  typedef enum logic [1:0] {
    ST_ZERO_CHUNK = 2'd0,
    ST_TRUNCATED  = 2'd1,
    ST_MALFORMED  = 2'd2,
    ST_OVERFLOW   = 2'd3
  } end_status_t;

  // One input transaction.
  typedef struct packed {
    logic [7:0] body_byte;
    logic       input_last;
  } in_item_t;

  // Control state of the size line parser.
  typedef struct packed {
    num_phase_t num_phase;
    logic       nonblank;
    logic       in_ext;
    logic       pending_cr;
  } line_ctl_t;

  // Outcome of one byte on a size line.
  typedef struct packed {
    logic        ended;
    end_status_t status;
    logic        start_data;
  } line_res_t;

  localparam line_ctl_t LINE_CTL_CLEAR = '{
    num_phase:  NP_BEFORE,
    nonblank:   1'b0,
    in_ext:     1'b0,
    pending_cr: 1'b0
  };

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      return {1'b1, c[3:0]};
    end else if (c >= CH_LA && c <= CH_LF_A) begin
      t = c - LOWER_OFS;
      return {1'b1, t[3:0]};
    end else if (c >= CH_UA && c <= CH_UF) begin
      t = c - UPPER_OFS;
      return {1'b1, t[3:0]};
    end
    return 5'b0_0000;
  endfunction

  // Whitespace that may precede the size.
  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
           (c == CH_FF) || (c == CH_CR);
  endfunction

endpackage

`default_nettype wire

// ===== design/hcbd_if.sv =====
`default_nettype none

// Input channel: one body byte per transaction.
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       input_last;

  modport source (output valid, output body_byte, output input_last, input ready);
  modport sink (input valid, input body_byte, input input_last, output ready);
endinterface

// Result channel: one decoded byte or end marker per transaction.
interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_data;
  logic       end_of_body;
  logic [1:0] end_status;

  modport source (output valid, output data_byte, output has_data, output end_of_body,
                  output end_status, input ready);
  modport sink (input valid, input data_byte, input has_data, input end_of_body,
                input end_status, output ready);
endinterface

`default_nettype wire

// ===== design/http_chunked_body_decoder.sv =====
// An accepted input transaction is held in the input register and then processed into the
// result register, which presents it; a full result register that is not being emptied stalls it.
// Throughput: one body byte per cycle while results are taken; a byte goes through an input
// register, one step of the size line parser and byte countdown, and the result register.
// Reset: synchronous, active-low rst_n clears both registers' valid flags and returns
// the decoder to the start of a size line; state also returns there after input_last.
`default_nettype none

module http_chunked_body_decoder #(
  parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  hcbd_in_if.sink   in_ch,
  hcbd_out_if.source out_ch
);
  import hcbd_pkg::*;

  // Input register.
  logic     stg_valid;
  in_item_t stg_item;
  logic     fire;

  hcbd_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .take_i  (fire),
    .valid_o (stg_valid),
    .item_o  (stg_item)
  );

  // Decoder state.
  phase_t               phase_r,  phase_nxt;
  line_ctl_t            ctl_r,    ctl_nxt;
  logic [SIZE_BITS-1:0] size_r,   size_nxt;
  logic [SIZE_BITS-1:0] remain_r, remain_nxt;

  // Result register.
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  data_r,      data_nxt;
  logic        has_r,       has_nxt;
  logic        eob_r,       eob_nxt;
  end_status_t status_r,    status_nxt;

  line_ctl_t            p_ctl;
  logic [SIZE_BITS-1:0] p_size;
  line_res_t            p_res;

  hcbd_line_parser #(
    .SIZE_BITS (SIZE_BITS)
  ) u_line_parser (
    .ctl_i  (ctl_r),
    .size_i (size_r),
    .byte_i (stg_item.body_byte),
    .ctl_o  (p_ctl),
    .size_o (p_size),
    .res_o  (p_res)
  );

  // A byte is processed when the result register is free or being emptied.
  assign fire = stg_valid && (!out_valid_r || out_ch.ready);

  // One decoding step per processed byte.
  always_comb begin
    phase_nxt     = phase_r;
    ctl_nxt       = ctl_r;
    size_nxt      = size_r;
    remain_nxt    = remain_r;
    has_nxt       = 1'b0;
    eob_nxt       = 1'b0;
    status_nxt    = ST_ZERO_CHUNK;
    data_nxt      = 8'h00;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (fire) begin
      unique case (phase_r)
        PH_DATA: begin
          has_nxt    = 1'b1;
          data_nxt   = stg_item.body_byte;
          remain_nxt = remain_r - SIZE_BITS'(1);
          if (remain_r == SIZE_BITS'(1)) begin
            phase_nxt = PH_LINE;
            ctl_nxt   = LINE_CTL_CLEAR;
            size_nxt  = '0;
          end
        end
        PH_LINE: begin
          ctl_nxt  = p_ctl;
          size_nxt = p_size;
          if (p_res.ended) begin
            eob_nxt    = 1'b1;
            status_nxt = p_res.status;
            phase_nxt  = PH_DONE;
          end else if (p_res.start_data) begin
            remain_nxt = size_r;
            phase_nxt  = PH_DATA;
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase

      // The body stops short of its zero chunk.
      if (!eob_nxt && stg_item.input_last && phase_nxt != PH_DONE) begin
        eob_nxt    = 1'b1;
        status_nxt = ST_TRUNCATED;
      end

      // Every body starts afresh after its last byte.
      if (stg_item.input_last) begin
        phase_nxt  = PH_LINE;
        ctl_nxt    = LINE_CTL_CLEAR;
        size_nxt   = '0;
        remain_nxt = '0;
      end

      out_valid_nxt = has_nxt || eob_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LINE;
      ctl_r       <= LINE_CTL_CLEAR;
      size_r      <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      ctl_r       <= ctl_nxt;
      size_r      <= size_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload loads only with a processed byte.
  always_ff @(posedge clk) begin
    if (fire) begin
      data_r   <= data_nxt;
      has_r    <= has_nxt;
      eob_r    <= eob_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.data_byte   = data_r;
  assign out_ch.has_data    = has_r;
  assign out_ch.end_of_body = eob_r;
  assign out_ch.end_status  = status_r;

endmodule

`default_nettype wire

// ===== design/hcbd_in_stage.sv =====
`default_nettype none

module hcbd_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  hcbd_in_if.sink                in_ch,
  input  wire logic              take_i,
  output logic                   valid_o,
  output hcbd_pkg::in_item_t     item_o
);
  import hcbd_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     load;

  // The register can load whenever it is empty or its contents leave this cycle.
  assign in_ch.ready = !valid_r || take_i;
  assign load        = in_ch.valid && in_ch.ready;
  assign valid_nxt   = load || (valid_r && !take_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload holds no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      item_r.body_byte  <= in_ch.body_byte;
      item_r.input_last <= in_ch.input_last;
    end
  end

  assign valid_o = valid_r;
  assign item_o  = item_r;

endmodule

`default_nettype wire

// ===== design/hcbd_line_parser.sv =====
`default_nettype none

module hcbd_line_parser #(
  parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
  input  wire hcbd_pkg::line_ctl_t  ctl_i,
  input  wire logic [SIZE_BITS-1:0] size_i,
  input  wire logic [7:0]        byte_i,
  output hcbd_pkg::line_ctl_t    ctl_o,
  output logic [SIZE_BITS-1:0]   size_o,
  output hcbd_pkg::line_res_t    res_o
);
  import hcbd_pkg::*;

  typedef struct packed {
    line_ctl_t            ctl;
    logic [SIZE_BITS-1:0] size;
  } line_st_t;

  // One ordinary byte of a size line.
  function automatic line_st_t feed(input line_st_t s, input logic [7:0] c);
    line_st_t   r;
    logic [4:0] hd;
    r  = s;
    hd = hex_digit(c);
    if (!s.ctl.in_ext) begin
      if (c == CH_SEMI) begin
        r.ctl.in_ext = 1'b1;
      end else begin
        if (c != CH_SP && c != CH_TAB) begin
          r.ctl.nonblank = 1'b1;
        end
        unique case (s.ctl.num_phase)
          NP_BEFORE: begin
            if (!is_space(c)) begin
              if (c == CH_ZERO) begin
                r.ctl.num_phase = NP_ZERO;
              end else if (hd[4]) begin
                r.size          = SIZE_BITS'(hd[3:0]);
                r.ctl.num_phase = NP_DIGITS;
              end else begin
                r.ctl.num_phase = NP_BAD;
              end
            end
          end
          NP_ZERO: begin
            if (c == CH_LX || c == CH_UX) begin
              r.ctl.num_phase = NP_PREFIX;
            end else if (hd[4]) begin
              r.size          = SIZE_BITS'(hd[3:0]);
              r.ctl.num_phase = NP_DIGITS;
            end else begin
              r.ctl.num_phase = NP_AFTER;
            end
          end
          NP_PREFIX: begin
            if (hd[4]) begin
              r.size          = SIZE_BITS'(hd[3:0]);
              r.ctl.num_phase = NP_DIGITS;
            end else begin
              r.ctl.num_phase = NP_AFTER;
            end
          end
          NP_DIGITS: begin
            if (hd[4]) begin
              // A digit that would push bits out of the top is an overflow.
              if (s.size[SIZE_BITS-1 -: 4] != 4'h0) begin
                r.ctl.num_phase = NP_OVER;
              end else begin
                r.size = {s.size[SIZE_BITS-5:0], hd[3:0]};
              end
            end else begin
              r.ctl.num_phase = NP_AFTER;
            end
          end
          NP_AFTER, NP_BAD, NP_OVER: begin
          end
          default: begin
          end
        endcase
      end
    end
    return r;
  endfunction

  line_st_t cur;
  line_st_t nxt;
  line_st_t tmp;
  logic     line_end;

  assign cur = {ctl_i, size_i};

  // Byte handling with CR held back until the following byte shows whether it ends the line.
  always_comb begin
    nxt      = cur;
    tmp      = cur;
    line_end = 1'b0;
    res_o    = '{ended: 1'b0, status: ST_ZERO_CHUNK, start_data: 1'b0};
    if (cur.ctl.pending_cr) begin
      nxt.ctl.pending_cr = 1'b0;
      if (byte_i == CH_LF) begin
        line_end = 1'b1;
      end else begin
        tmp = feed(nxt, CH_CR);
        if (byte_i == CH_CR) begin
          tmp.ctl.pending_cr = 1'b1;
          nxt = tmp;
        end else begin
          nxt = feed(tmp, byte_i);
        end
      end
    end else if (byte_i == CH_CR) begin
      nxt.ctl.pending_cr = 1'b1;
    end else begin
      nxt = feed(cur, byte_i);
    end

    // Line complete: blank lines are skipped, otherwise the number's phase and the size decide.
    if (line_end) begin
      if (!cur.ctl.nonblank) begin
        nxt.ctl  = LINE_CTL_CLEAR;
        nxt.size = '0;
      end else if (cur.ctl.num_phase == NP_BEFORE || cur.ctl.num_phase == NP_BAD) begin
        res_o.ended  = 1'b1;
        res_o.status = ST_MALFORMED;
      end else if (cur.ctl.num_phase == NP_OVER) begin
        res_o.ended  = 1'b1;
        res_o.status = ST_OVERFLOW;
      end else if (cur.size == '0) begin
        res_o.ended  = 1'b1;
        res_o.status = ST_ZERO_CHUNK;
      end else begin
        res_o.start_data = 1'b1;
        nxt.ctl          = LINE_CTL_CLEAR;
        nxt.size         = '0;
      end
    end
  end

  assign ctl_o  = nxt.ctl;
  assign size_o = nxt.size;

endmodule

`default_nettype wire
